// ----- sv/tcfs_pkg.sv -----
// Shared widths, codes, defaults and controller/datapath interface types.
package tcfs_pkg;

   // Field and state widths
   localparam int RAW_W      = 12;
   localparam int SUM_W      = 17;
   localparam int CNT_W      = 5;
   localparam int SPAN_W     = 10;
   localparam int OFS_W      = 9;
   localparam int PIX_W      = 11;
   localparam int COMP_W     = 10;
   localparam int CSR_ADDR_W = 3;

   // Divider operand widths: 2*num*span + den fits in 24 bits, 2*den needs 13
   localparam int DIV_DW = 24;
   localparam int DIV_VW = 13;

   // Parameter defaults
   localparam int SAMPLES_DEF = 18;
   localparam int X_COMP_DEF  = 0;
   localparam int Y_COMP_DEF  = 0;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_X_RAW_MIN  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_X_RAW_MAX  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_RAW_MIN  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_RAW_MAX  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_X_SPAN     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_SPAN     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_X_OFFSET   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_OFFSET   = 3'd7;

   // Register reset values
   localparam logic [RAW_W-1:0]  RST_RAW_MIN = 12'd600;
   localparam logic [RAW_W-1:0]  RST_RAW_MAX = 12'd3400;
   localparam logic [SPAN_W-1:0] RST_X_SPAN  = 10'd210;
   localparam logic [SPAN_W-1:0] RST_Y_SPAN  = 10'd290;
   localparam logic [OFS_W-1:0]  RST_OFFSET  = 9'd7;

   // Datapath operation codes: which axis is being scaled
   typedef logic op_type;
   localparam op_type OP_SCALE_X = 1'b0;
   localparam op_type OP_SCALE_Y = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic   accept;    // input transfer this cycle
      logic   mean_en;   // register both trimmed means
      logic   mul_en;    // register scaled numerator for op's axis
      logic   div_load;  // start the divider on op's operands
      op_type op;        // current operation, held through a division
      logic   emit;      // register the result and clear the burst
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_sample; // next accepted pair closes the burst
      logic div_done;    // divider quotient ready this cycle
   } status_type;

endpackage

// ----- sv/touch_coordinate_filter_scale.sv -----
// Top level: touch sample burst filter with trimmed mean, clamp and pixel scaling.
// Every pair but the last of a burst is taken without raising busy; start may stay high throughout.
// The last pair raises busy through a mean state, then per axis a multiply, a divider load
// and a wait on the bit-serial divider, and last an output state.
// rsp_strobe pulses in the cycle in which busy falls.
// The receiver cannot stall. Synchronous reset loads default calibration, empties the burst.
module touch_coordinate_filter_scale import tcfs_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEF,
   parameter int X_COMP  = X_COMP_DEF,
   parameter int Y_COMP  = Y_COMP_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [RAW_W-1:0]      req_sample_x,
   input  logic [RAW_W-1:0]      req_sample_y,
   output logic                  rsp_strobe,
   output logic [PIX_W-1:0]      rsp_pixel_x,
   output logic [PIX_W-1:0]      rsp_pixel_y,
   output logic                  rsp_cal_error,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [RAW_W-1:0]      csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tcfs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tcfs_datapath #(
      .SAMPLES (SAMPLES),
      .X_COMP  (X_COMP),
      .Y_COMP  (Y_COMP)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .sample_x      (req_sample_x),
      .sample_y      (req_sample_y),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .rsp_strobe    (rsp_strobe),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_cal_error (rsp_cal_error)
   );

   // A transfer that does not close a burst leaves the block free
   a_mid_burst_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !status.last_sample) |=> !busy)
      else $error("busy after a mid-burst transfer");

   // A result only follows a compute sequence
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result strobe without preceding compute");

   // Results are single-cycle pulses
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // The divider never finishes while the block is idle
   a_div_in_compute: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> busy)
      else $error("divider done outside compute");

endmodule

// ----- sv/tcfs_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by both axis scalings.
module tcfs_div #(
   parameter int DW = 24,
   parameter int VW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic          done
);

   localparam int CW = $clog2(DW);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;

   logic [VW:0]   shifted;
   logic [VW:0]   diff;
   logic          ge;
   logic          last;

   // One restoring step
   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign last    = cnt_ff == CW'(DW - 1);

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[DW-2:0], ge};
         rem_in = ge ? diff[VW-1:0] : shifted[VW-1:0];
         cnt_in = cnt_ff + CW'(1);
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Operands
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (load) begin
         dvs_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- sv/tcfs_datapath.sv -----
// Burst accumulation, calibration registers, clamp/scale arithmetic and result register.
module tcfs_datapath import tcfs_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEF,
   parameter int X_COMP  = X_COMP_DEF,
   parameter int Y_COMP  = Y_COMP_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [RAW_W-1:0]      sample_x,
   input  logic [RAW_W-1:0]      sample_y,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [RAW_W-1:0]      csr_wdata,
   output logic                  rsp_strobe,
   output logic [PIX_W-1:0]      rsp_pixel_x,
   output logic [PIX_W-1:0]      rsp_pixel_y,
   output logic                  rsp_cal_error
);

   // Mean by reciprocal multiplication: exact floor for any SUM_W-bit trimmed sum
   localparam int MEAN_DIV = SAMPLES - 2;
   localparam int MEAN_SH  = SUM_W + $clog2(MEAN_DIV);
   localparam int RCP_W    = SUM_W + 1;
   localparam int MEAN_RCP = ((1 << MEAN_SH) + MEAN_DIV - 1) / MEAN_DIV;
   localparam int MPROD_W  = SUM_W + RCP_W;

   function automatic logic [RAW_W-1:0] adj_min(input logic [RAW_W-1:0] rmin,
                                                input logic [RAW_W-1:0] comp);
      return (rmin > comp) ? (rmin - comp) : '0;
   endfunction

   // Calibration registers
   logic [RAW_W-1:0]  x_raw_min_ff, x_raw_max_ff, y_raw_min_ff, y_raw_max_ff;
   logic [SPAN_W-1:0] x_span_ff, y_span_ff;
   logic [OFS_W-1:0]  x_offset_ff, y_offset_ff;

   // Burst state
   logic [SUM_W-1:0]  sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [RAW_W-1:0]  low_x_ff, low_x_in, high_x_ff, high_x_in;
   logic [RAW_W-1:0]  low_y_ff, low_y_in, high_y_ff, high_y_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Intermediate results
   logic [RAW_W-1:0]  mean_x_ff, mean_y_ff;
   logic [DIV_DW-1:0] num_ff, num_in;
   logic [PIX_W-1:0]  quot_x_ff, quot_y_ff;

   // Result register
   logic              strobe_ff;
   logic [PIX_W-1:0]  pix_x_ff, pix_y_ff;
   logic              err_ff;

   logic [RAW_W-1:0]  adj_x, adj_y, den_x, den_y;
   logic              err_x, err_y;
   logic [SUM_W-1:0]  trim_x, trim_y;
   logic [MPROD_W-1:0] mprod_x, mprod_y;
   logic              sel_y;
   logic [RAW_W-1:0]  m_mean, m_adj, m_max, m_raised, m_clamped, m_num, m_den;
   logic [SPAN_W-1:0] m_span;
   logic [RAW_W+SPAN_W-1:0] m_prod;
   logic [DIV_DW-1:0] div_quot;
   logic [DIV_VW-1:0] div_divisor;
   logic              div_done;

   // Per-axis calibration terms
   assign adj_x = adj_min(x_raw_min_ff, RAW_W'(X_COMP));
   assign adj_y = adj_min(y_raw_min_ff, RAW_W'(Y_COMP));
   assign err_x = x_raw_max_ff <= adj_x;
   assign err_y = y_raw_max_ff <= adj_y;
   assign den_x = x_raw_max_ff - adj_x;
   assign den_y = y_raw_max_ff - adj_y;

   // Trimmed sums: extremes dropped
   assign trim_x = sum_x_ff - SUM_W'(low_x_ff) - SUM_W'(high_x_ff);
   assign trim_y = sum_y_ff - SUM_W'(low_y_ff) - SUM_W'(high_y_ff);

   // Trimmed sums times the reciprocal of the kept sample count
   assign mprod_x = MPROD_W'(trim_x) * MPROD_W'(MEAN_RCP);
   assign mprod_y = MPROD_W'(trim_y) * MPROD_W'(MEAN_RCP);

   // Clamp and multiply for the selected axis
   assign sel_y     = cmd.op == OP_SCALE_Y;
   assign m_mean    = sel_y ? mean_y_ff : mean_x_ff;
   assign m_adj     = sel_y ? adj_y : adj_x;
   assign m_max     = sel_y ? y_raw_max_ff : x_raw_max_ff;
   assign m_span    = sel_y ? y_span_ff : x_span_ff;
   assign m_den     = sel_y ? den_y : den_x;
   assign m_raised  = (m_mean < m_adj) ? m_adj : m_mean;
   assign m_clamped = (m_raised > m_max) ? m_max : m_raised;
   assign m_num     = m_clamped - m_adj;
   assign m_prod    = m_num * m_span;
   assign num_in    = DIV_DW'({m_prod, 1'b0}) + DIV_DW'(m_den);

   // Divider operands: numerator register over twice the axis range
   assign div_divisor = {m_den, 1'b0};

   tcfs_div #(
      .DW (DIV_DW),
      .VW (DIV_VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (cmd.div_load),
      .dividend (num_ff),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .done     (div_done)
   );

   // Burst accumulation
   always_comb begin
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      low_x_in  = low_x_ff;
      high_x_in = high_x_ff;
      low_y_in  = low_y_ff;
      high_y_in = high_y_ff;
      count_in  = count_ff;
      if (cmd.emit) begin
         sum_x_in  = '0;
         sum_y_in  = '0;
         low_x_in  = '1;
         high_x_in = '0;
         low_y_in  = '1;
         high_y_in = '0;
         count_in  = '0;
      end else if (cmd.accept) begin
         sum_x_in  = sum_x_ff + SUM_W'(sample_x);
         sum_y_in  = sum_y_ff + SUM_W'(sample_y);
         low_x_in  = (sample_x < low_x_ff) ? sample_x : low_x_ff;
         high_x_in = (sample_x > high_x_ff) ? sample_x : high_x_ff;
         low_y_in  = (sample_y < low_y_ff) ? sample_y : low_y_ff;
         high_y_in = (sample_y > high_y_ff) ? sample_y : high_y_ff;
         count_in  = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         low_x_ff  <= '1;
         high_x_ff <= '0;
         low_y_ff  <= '1;
         high_y_ff <= '0;
         count_ff  <= '0;
      end else begin
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         low_x_ff  <= low_x_in;
         high_x_ff <= high_x_in;
         low_y_ff  <= low_y_in;
         high_y_ff <= high_y_in;
         count_ff  <= count_in;
      end
   end

   // Calibration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_raw_min_ff <= RST_RAW_MIN;
         x_raw_max_ff <= RST_RAW_MAX;
         y_raw_min_ff <= RST_RAW_MIN;
         y_raw_max_ff <= RST_RAW_MAX;
         x_span_ff    <= RST_X_SPAN;
         y_span_ff    <= RST_Y_SPAN;
         x_offset_ff  <= RST_OFFSET;
         y_offset_ff  <= RST_OFFSET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_X_RAW_MIN: x_raw_min_ff <= csr_wdata;
            REG_X_RAW_MAX: x_raw_max_ff <= csr_wdata;
            REG_Y_RAW_MIN: y_raw_min_ff <= csr_wdata;
            REG_Y_RAW_MAX: y_raw_max_ff <= csr_wdata;
            REG_X_SPAN:    x_span_ff    <= csr_wdata[SPAN_W-1:0];
            REG_Y_SPAN:    y_span_ff    <= csr_wdata[SPAN_W-1:0];
            REG_X_OFFSET:  x_offset_ff  <= csr_wdata[OFS_W-1:0];
            REG_Y_OFFSET:  y_offset_ff  <= csr_wdata[OFS_W-1:0];
            default: ;
         endcase
      end
   end

   // Mean, numerator and quotient capture
   always_ff @(posedge clock) begin
      if (cmd.mean_en) begin
         mean_x_ff <= mprod_x[MEAN_SH +: RAW_W];
         mean_y_ff <= mprod_y[MEAN_SH +: RAW_W];
      end
      if (cmd.mul_en) begin
         num_ff <= num_in;
      end
      if (div_done) begin
         unique case (cmd.op)
            OP_SCALE_X: quot_x_ff <= div_quot[PIX_W-1:0];
            OP_SCALE_Y: quot_y_ff <= div_quot[PIX_W-1:0];
         endcase
      end
   end

   // Result register; an axis that cannot be scaled gives its offset
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         pix_x_ff <= err_x ? PIX_W'(x_offset_ff) : quot_x_ff + PIX_W'(x_offset_ff);
         pix_y_ff <= err_y ? PIX_W'(y_offset_ff) : quot_y_ff + PIX_W'(y_offset_ff);
         err_ff   <= err_x | err_y;
      end
   end

   assign status.last_sample = count_ff == CNT_W'(SAMPLES - 1);
   assign status.div_done    = div_done;

   assign rsp_strobe    = strobe_ff;
   assign rsp_pixel_x   = pix_x_ff;
   assign rsp_pixel_y   = pix_y_ff;
   assign rsp_cal_error = err_ff;

endmodule

// ----- sv/tcfs_ctrl.sv -----
// Sequencer: takes samples, forms the means, then runs the two scalings through the divider.
module tcfs_ctrl import tcfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MEAN    = 4'd1;
   localparam logic [3:0] S_MUL_X   = 4'd2;
   localparam logic [3:0] S_LOAD_SX = 4'd3;
   localparam logic [3:0] S_WAIT_SX = 4'd4;
   localparam logic [3:0] S_MUL_Y   = 4'd5;
   localparam logic [3:0] S_LOAD_SY = 4'd6;
   localparam logic [3:0] S_WAIT_SY = 4'd7;
   localparam logic [3:0] S_EMIT    = 4'd8;

   logic [3:0] state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.accept   = 1'b0;
      cmd.mean_en  = 1'b0;
      cmd.mul_en   = 1'b0;
      cmd.div_load = 1'b0;
      cmd.op       = OP_SCALE_X;
      cmd.emit     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = start;
            if (start && status.last_sample) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            cmd.mean_en = 1'b1;
            state_in    = S_MUL_X;
         end
         S_MUL_X: begin
            cmd.op     = OP_SCALE_X;
            cmd.mul_en = 1'b1;
            state_in   = S_LOAD_SX;
         end
         S_LOAD_SX: begin
            cmd.op       = OP_SCALE_X;
            cmd.div_load = 1'b1;
            state_in     = S_WAIT_SX;
         end
         S_WAIT_SX: begin
            cmd.op = OP_SCALE_X;
            if (status.div_done) begin
               state_in = S_MUL_Y;
            end
         end
         S_MUL_Y: begin
            cmd.op     = OP_SCALE_Y;
            cmd.mul_en = 1'b1;
            state_in   = S_LOAD_SY;
         end
         S_LOAD_SY: begin
            cmd.op       = OP_SCALE_Y;
            cmd.div_load = 1'b1;
            state_in     = S_WAIT_SY;
         end
         S_WAIT_SY: begin
            cmd.op = OP_SCALE_Y;
            if (status.div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for the touch burst filter: trimmed mean, clamp and pixel scaling.
module tb;
   import tcfs_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 120;
   localparam int PHASES         = 8;
   localparam int BURSTS_PER_PH  = 5;

   typedef struct {
      logic [RAW_W-1:0] sx;
      logic [RAW_W-1:0] sy;
   } raw_pair_type;

   typedef struct {
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      logic             err;
   } touch_point_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [RAW_W-1:0]      req_sample_x = '0;
   logic [RAW_W-1:0]      req_sample_y = '0;
   logic                  rsp_strobe;
   logic [PIX_W-1:0]      rsp_pixel_x;
   logic [PIX_W-1:0]      rsp_pixel_y;
   logic                  rsp_cal_error;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [RAW_W-1:0]      csr_wdata = '0;

   // Pending sample pairs, expected touch points, failure count
   raw_pair_type    sample_backlog[$];
   touch_point_type expected_points[$];
   int              fail_count = 0;
   int              idle_pct = 0;
   int              quiet_cycles = 0;

   // Calibration copy
   logic [RAW_W-1:0]  cal_x_min = RST_RAW_MIN;
   logic [RAW_W-1:0]  cal_x_max = RST_RAW_MAX;
   logic [RAW_W-1:0]  cal_y_min = RST_RAW_MIN;
   logic [RAW_W-1:0]  cal_y_max = RST_RAW_MAX;
   logic [SPAN_W-1:0] cal_x_span = RST_X_SPAN;
   logic [SPAN_W-1:0] cal_y_span = RST_Y_SPAN;
   logic [OFS_W-1:0]  cal_x_ofs = RST_OFFSET;
   logic [OFS_W-1:0]  cal_y_ofs = RST_OFFSET;

   // Burst accumulator copy
   logic [SUM_W-1:0] acc_x = '0;
   logic [SUM_W-1:0] acc_y = '0;
   logic [RAW_W-1:0] min_x = '1;
   logic [RAW_W-1:0] max_x = '0;
   logic [RAW_W-1:0] min_y = '1;
   logic [RAW_W-1:0] max_y = '0;
   logic [CNT_W-1:0] burst_len = '0;

   touch_coordinate_filter_scale dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample_x(req_sample_x), .req_sample_y(req_sample_y),
      .rsp_strobe(rsp_strobe), .rsp_pixel_x(rsp_pixel_x), .rsp_pixel_y(rsp_pixel_y),
      .rsp_cal_error(rsp_cal_error),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pixel for one axis: trimmed mean, clamp, round-half-up scaling, offset
   function automatic logic [PIX_W-1:0] axis_pixel(
      input logic [SUM_W-1:0] sum, input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi,
      input logic [RAW_W-1:0] rmin, input logic [RAW_W-1:0] rmax, input int unsigned comp,
      input logic [SPAN_W-1:0] span, input logic [OFS_W-1:0] ofs, inout logic err);
      int unsigned trimmed, mean, adj, den, num, q;
      trimmed = int'(sum) - int'(lo) - int'(hi);
      mean = trimmed / int'(SAMPLES_DEF - 2);
      adj = (rmin > comp) ? rmin - comp : 0;
      if (rmax <= adj) begin
         err = 1'b1;
         return PIX_W'(ofs);
      end
      if (mean < adj) mean = adj;
      if (mean > rmax) mean = rmax;
      den = rmax - adj;
      num = mean - adj;
      q = (2 * num * span + den) / (2 * den) + ofs;
      return q[PIX_W-1:0];
   endfunction

   // Fold one accepted pair into the burst; the closing pair yields a touch point
   function automatic void absorb_pair(input logic [RAW_W-1:0] sx, input logic [RAW_W-1:0] sy);
      touch_point_type pt;
      if (sx < min_x) min_x = sx;
      if (sx > max_x) max_x = sx;
      if (sy < min_y) min_y = sy;
      if (sy > max_y) max_y = sy;
      acc_x = acc_x + sx;
      acc_y = acc_y + sy;
      burst_len = burst_len + 1'b1;
      if (burst_len == CNT_W'(SAMPLES_DEF)) begin
         pt.err = 1'b0;
         pt.px = axis_pixel(acc_x, min_x, max_x, cal_x_min, cal_x_max, X_COMP_DEF,
                            cal_x_span, cal_x_ofs, pt.err);
         pt.py = axis_pixel(acc_y, min_y, max_y, cal_y_min, cal_y_max, Y_COMP_DEF,
                            cal_y_span, cal_y_ofs, pt.err);
         expected_points.push_back(pt);
         acc_x = '0;
         acc_y = '0;
         min_x = '1;
         max_x = '0;
         min_y = '1;
         max_y = '0;
         burst_len = '0;
      end
   endfunction

   // Sample near a centre, held inside the ADC range
   function automatic logic [RAW_W-1:0] near(input int centre);
      int v;
      v = centre + int'($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return RAW_W'(v);
   endfunction

   // One burst of random pairs in one of several shapes
   task automatic queue_burst();
      raw_pair_type rp;
      int           shape, cx, cy;
      shape = $urandom_range(0, 5);
      cx = $urandom_range(0, 4095);
      cy = $urandom_range(0, 4095);
      for (int i = 0; i < SAMPLES_DEF; i++) begin
         case (shape)
            0, 1, 2: begin
               // realistic press with the odd outlier for the trim to drop
               if ($urandom_range(0, 7) == 0) begin
                  rp.sx = RAW_W'($urandom);
                  rp.sy = RAW_W'($urandom);
               end else begin
                  rp.sx = near(cx);
                  rp.sy = near(cy);
               end
            end
            3: begin
               rp.sx = RAW_W'($urandom);
               rp.sy = RAW_W'($urandom);
            end
            4: begin
               rp.sx = $urandom_range(0, 1) ? '1 : '0;
               rp.sy = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
               rp.sx = RAW_W'(cx);
               rp.sy = RAW_W'(cy);
            end
         endcase
         sample_backlog.push_back(rp);
      end
   endtask

   // Register write; the model copy follows at once since the block is idle
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [RAW_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         REG_X_RAW_MIN: cal_x_min  = value;
         REG_X_RAW_MAX: cal_x_max  = value;
         REG_Y_RAW_MIN: cal_y_min  = value;
         REG_Y_RAW_MAX: cal_y_max  = value;
         REG_X_SPAN:    cal_x_span = value[SPAN_W-1:0];
         REG_Y_SPAN:    cal_y_span = value[SPAN_W-1:0];
         REG_X_OFFSET:  cal_x_ofs  = value[OFS_W-1:0];
         default:       cal_y_ofs  = value[OFS_W-1:0];
      endcase
   endtask

   // Calibration for a phase: edge settings first, then random ones
   task automatic load_calibration(input int phase);
      logic [RAW_W-1:0] lo, hi;
      case (phase)
         1: begin
            // widest range, widest span, largest and smallest offsets
            write_reg(REG_X_RAW_MIN, 12'd0);
            write_reg(REG_X_RAW_MAX, 12'd4095);
            write_reg(REG_Y_RAW_MIN, 12'd0);
            write_reg(REG_Y_RAW_MAX, 12'd4095);
            write_reg(REG_X_SPAN, 12'hFFF);
            write_reg(REG_Y_SPAN, 12'd1023);
            write_reg(REG_X_OFFSET, 12'h1FF);
            write_reg(REG_Y_OFFSET, 12'd0);
         end
         2: begin
            // both axes uncalibrated: max below min on X, equal on Y
            write_reg(REG_X_RAW_MIN, 12'd4095);
            write_reg(REG_X_RAW_MAX, 12'd0);
            write_reg(REG_Y_RAW_MIN, 12'd2000);
            write_reg(REG_Y_RAW_MAX, 12'd2000);
            write_reg(REG_X_SPAN, 12'd0);
            write_reg(REG_Y_SPAN, 12'hC00);
            write_reg(REG_X_OFFSET, 12'd300);
            write_reg(REG_Y_OFFSET, 12'hFFF);
         end
         3: begin
            // one-count ranges, so the rounding decides everything
            write_reg(REG_X_RAW_MIN, 12'd1000);
            write_reg(REG_X_RAW_MAX, 12'd1001);
            write_reg(REG_Y_RAW_MIN, 12'd0);
            write_reg(REG_Y_RAW_MAX, 12'd1);
            write_reg(REG_X_SPAN, 12'd1023);
            write_reg(REG_Y_SPAN, 12'd1);
            write_reg(REG_X_OFFSET, 12'd0);
            write_reg(REG_Y_OFFSET, 12'd0);
         end
         default: begin
            lo = RAW_W'($urandom_range(0, 2500));
            hi = $urandom_range(1, 8) == 1 ? RAW_W'($urandom_range(0, 4095))
                                           : RAW_W'($urandom_range(lo + 1, 4095));
            write_reg(REG_X_RAW_MIN, lo);
            write_reg(REG_X_RAW_MAX, hi);
            lo = RAW_W'($urandom_range(0, 2500));
            hi = $urandom_range(1, 8) == 1 ? RAW_W'($urandom_range(0, 4095))
                                           : RAW_W'($urandom_range(lo + 1, 4095));
            write_reg(REG_Y_RAW_MIN, lo);
            write_reg(REG_Y_RAW_MAX, hi);
            write_reg(REG_X_SPAN, RAW_W'($urandom));
            write_reg(REG_Y_SPAN, RAW_W'($urandom));
            write_reg(REG_X_OFFSET, RAW_W'($urandom));
            write_reg(REG_Y_OFFSET, RAW_W'($urandom));
         end
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Driver: hold a pair until taken, otherwise offer the next one or idle
   always @(posedge clock) begin
      raw_pair_type rp;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) absorb_pair(req_sample_x, req_sample_y);
         if (!(start && busy)) begin
            if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               rp = sample_backlog.pop_front();
               start        <= 1'b1;
               req_sample_x <= rp.sx;
               req_sample_y <= rp.sy;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobe is checked against the oldest expected point
   always @(posedge clock) begin
      touch_point_type pt;
      if (!reset && rsp_strobe) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d err=%0b", $time,
                     rsp_pixel_x, rsp_pixel_y, rsp_cal_error);
            fail_count++;
         end else begin
            pt = expected_points.pop_front();
            if (rsp_pixel_x !== pt.px) begin
               $display("%0t: pixel_x expected %0d got %0d", $time, pt.px, rsp_pixel_x);
               fail_count++;
            end
            if (rsp_pixel_y !== pt.py) begin
               $display("%0t: pixel_y expected %0d got %0d", $time, pt.py, rsp_pixel_y);
               fail_count++;
            end
            if (rsp_cal_error !== pt.err) begin
               $display("%0t: cal_error expected %0b got %0b", $time, pt.err, rsp_cal_error);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sequence: reset, then phases of calibration and bursts
   initial begin
      int idle_plan[4];
      raw_pair_type rp;
      idle_plan = '{0, 72, 0, 17};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) load_calibration(p);
         idle_pct = idle_plan[p % 4];
         if (p == 0) begin
            // extremes on X, Y pinned at full scale to exercise the upper clamp
            for (int i = 0; i < SAMPLES_DEF; i++) begin
               case (i % 3)
                  0:       rp.sx = 12'd0;
                  1:       rp.sx = 12'd4095;
                  default: rp.sx = (i % 2) ? 12'h555 : 12'hAAA;
               endcase
               rp.sy = 12'd4095;
               sample_backlog.push_back(rp);
            end
         end
         for (int b = (p == 0) ? 1 : 0; b < BURSTS_PER_PH; b++) queue_burst();
         wait (sample_backlog.size() == 0 && !start);
         wait (expected_points.size() == 0);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      if (fail_count == 0 && expected_points.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
